// ----- rtl/core/dac_setpoint_ramp_calibrator_assert.svh -----
// Assertion macros shared by the setpoint calibrator RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef DAC_SETPOINT_RAMP_CALIBRATOR_ASSERT_SVH
`define DAC_SETPOINT_RAMP_CALIBRATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define DSRC_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define DSRC_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define DSRC_ASSERT(lbl, ck, rn, prop, msg)
`define DSRC_NEVER(lbl, ck, rn, cond, msg)
`endif

`endif

// ----- rtl/core/dsrc_pkg.sv -----
// Shared types, codes and helpers of the DAC setpoint ramp calibrator.
// No dependencies; used by every module of the block.
package dsrc_pkg;

	localparam int CHAN_MAX         = 8;
	localparam int SLOT_W           = 3;
	localparam int DEF_NUM_CHANNELS = 4;
	localparam int DEF_CAL_STEP     = 1024;
	localparam int QUEUE_DEPTH      = 2;

	localparam int CAL_DEPTH = 256;
	localparam int CAL_AW    = 8;

	localparam int S_DATA_W  = 72;
	localparam int S_USER_W  = 3;
	localparam int M_DATA_W  = 40;
	localparam int M_USER_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int MAP_W     = 64;

	localparam logic [15:0] CODE_MAX = 16'hFFFF;

	// command kinds
	localparam logic [2:0] KIND_SET     = 3'd0;
	localparam logic [2:0] KIND_SET_ALL = 3'd1;
	localparam logic [2:0] KIND_INIT    = 3'd2;
	localparam logic [2:0] KIND_NEXT    = 3'd3;
	localparam logic [2:0] KIND_READ    = 3'd4;
	localparam logic [2:0] KIND_LOAD    = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DAC_MAP  = 1'b1;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} slot_match_t;

	// classified command, front to back
	typedef struct packed {
		logic [2:0]        kind;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       code;
		logic [15:0]       ramp_step;
		logic [15:0]       ramp_count;
		logic [7:0]        cal_index;   // entry within the channel
		logic [7:0]        cal_value;
	} cmd_t;

	// first slot below n whose map byte equals addr
	function automatic slot_match_t find_slot(input logic [MAP_W-1:0] map,
		input logic [7:0] addr, input int n);
		slot_match_t res;
		res = '0;
		for (int i = CHAN_MAX - 1; i >= 0; i--) begin
			if (i < n && map[8*i +: 8] == addr) begin
				res.hit  = 1'b1;
				res.slot = SLOT_W'(i);
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/dsrc_front.sv -----
// Front end: accepts command words, matches the channel address and
// precomputes the calibration entry index. Depends on dsrc_pkg.
module dsrc_front #(
	parameter int NUM_CHANNELS = dsrc_pkg::DEF_NUM_CHANNELS,
	parameter int CAL_STEP     = dsrc_pkg::DEF_CAL_STEP
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dsrc_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [dsrc_pkg::S_USER_W-1:0] s_tuser,
	input  logic [dsrc_pkg::MAP_W-1:0]    chan_map,
	output logic                          push,
	output dsrc_pkg::cmd_t                push_data,
	input  logic                          full
);
	import dsrc_pkg::*;

	localparam int CAL_ENTRIES = 65535 / CAL_STEP + 1;
	// exact reciprocals: code / CAL_STEP and cal_index / CAL_ENTRIES
	localparam logic [31:0] RECIP_CODE = 32'(((64'd1 << 32) + CAL_STEP - 1) / CAL_STEP);
	localparam logic [15:0] RECIP_IDX  = 16'((65536 + CAL_ENTRIES - 1) / CAL_ENTRIES);

	logic        v_s1, v_s2;
	logic        adv1, adv2;
	logic [2:0]  kind_s1, kind_s2;
	logic [7:0]  chan_s1;
	logic [15:0] code_s1, code_s2, step_s1, step_s2, count_s1, count_s2;
	logic [7:0]  cidx_s1, cidx_s2, cval_s1, cval_s2;
	logic [47:0] prod_code_s1;
	logic [23:0] prod_idx_s1;
	logic        hit_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [7:0]  qcode_s2, qe_s2;
	slot_match_t match;
	logic [7:0]  qidx;

	assign adv2     = v_s2 && !full;
	assign adv1     = v_s1 && (!v_s2 || adv2);
	assign s_tready = !v_s1 || adv1;
	assign push     = adv2;

	assign match = find_slot(chan_map, chan_s1, NUM_CHANNELS);
	assign qidx  = prod_idx_s1[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (adv2)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1      <= s_tuser;
			chan_s1      <= s_tdata[7:0];
			code_s1      <= s_tdata[23:8];
			step_s1      <= s_tdata[39:24];
			count_s1     <= s_tdata[55:40];
			cidx_s1      <= s_tdata[63:56];
			cval_s1      <= s_tdata[71:64];
			prod_code_s1 <= {16'd0, s_tdata[23:8]} * {16'd0, RECIP_CODE};
			prod_idx_s1  <= {16'd0, s_tdata[63:56]} * {8'd0, RECIP_IDX};
		end
		if (adv1) begin
			kind_s2  <= kind_s1;
			hit_s2   <= match.hit;
			slot_s2  <= match.slot;
			code_s2  <= code_s1;
			step_s2  <= step_s1;
			count_s2 <= count_s1;
			cidx_s2  <= cidx_s1;
			cval_s2  <= cval_s1;
			qcode_s2 <= prod_code_s1[39:32];
			qe_s2    <= 8'(int'(qidx) * CAL_ENTRIES);   // never above cidx
		end
	end

	always_comb begin
		push_data            = '0;
		push_data.kind       = kind_s2;
		push_data.hit        = hit_s2;
		push_data.slot       = slot_s2;
		push_data.code       = code_s2;
		push_data.ramp_step  = step_s2;
		push_data.ramp_count = count_s2;
		push_data.cal_value  = cval_s2;
		// load wraps its index within the channel, set uses code / step
		push_data.cal_index  = (kind_s2 == KIND_LOAD) ? (cidx_s2 - qe_s2) : qcode_s2;
	end

endmodule

// ----- rtl/core/dsrc_queue.sv -----
// Small register queue between the front end and the back end.
// Depends on dsrc_pkg for the default depth and on the assertion header for the macros.
`include "dac_setpoint_ramp_calibrator_assert.svh"

module dsrc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dsrc_pkg::QUEUE_DEPTH   // power of two
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import dsrc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`DSRC_NEVER(a_push_full, clk, arst_n, push && full, "queue written while full")
	`DSRC_NEVER(a_pop_empty, clk, arst_n, pop && empty, "queue read while empty")
	`DSRC_ASSERT(a_count_step, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "queue count did not advance on push")

endmodule

// ----- rtl/core/dsrc_back.sv -----
// Back end: executes classified commands against the per-channel state and
// the calibration RAM, and drives the result word register. Depends on dsrc_pkg.
`include "dac_setpoint_ramp_calibrator_assert.svh"

module dsrc_back #(
	parameter int NUM_CHANNELS = dsrc_pkg::DEF_NUM_CHANNELS,
	parameter int CAL_STEP     = dsrc_pkg::DEF_CAL_STEP
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dsrc_pkg::cmd_t                head,
	input  logic                          head_valid,
	output logic                          pop,
	input  logic [dsrc_pkg::MAP_W-1:0]    chan_map,
	input  logic [dsrc_pkg::MAP_W-1:0]    dac_map,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dsrc_pkg::M_DATA_W-1:0] m_tdata,
	output logic [dsrc_pkg::M_USER_W-1:0] m_tuser,
	output logic                          m_tlast
);
	import dsrc_pkg::*;

	localparam int CAL_ENTRIES = 65535 / CAL_STEP + 1;
	localparam int SW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef enum logic {S_IDLE, S_WAIT} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [SW-1:0] iter_q, cur_slot_q;

	logic [15:0] setpoint_q [NUM_CHANNELS];
	logic        mode_q     [NUM_CHANNELS];
	logic [15:0] inc_q      [NUM_CHANNELS];
	logic [15:0] rem_q      [NUM_CHANNELS];

	logic [7:0]  cal_mem [CAL_DEPTH];
	logic [CAL_DEPTH-1:0] cal_vld_q;
	logic [7:0]  cal_rd_q;
	logic        cal_rd_vld_q;

	logic        out_valid_q, out_frame_q, out_status_q, out_last_q;
	logic [7:0]  out_addr_q;
	logic [15:0] out_code_q, out_read_q;

	logic        out_free, out_load, need_cal, known, more, rd_en, wr_en;
	logic [SW-1:0] hs, issue_idx, all_slot, issue_slot;
	slot_match_t all_match;
	logic [7:0]  issue_byte, cal_idx, cal_byte;
	logic [CAL_AW-1:0] cal_addr;
	logic [15:0] sp, sp_next;
	logic [16:0] cal_sum;
	logic [15:0] cal_code;
	logic        s_frame, s_status;
	logic [7:0]  s_addr;
	logic [15:0] s_code, s_read;

	assign out_free = !out_valid_q || m_tready;
	assign need_cal = (head.kind == KIND_SET && head.hit) || head.kind == KIND_SET_ALL;
	assign known    = head.kind inside {[KIND_SET:KIND_LOAD]};
	assign more     = cmd_q.kind == KIND_SET_ALL && iter_q != SW'(NUM_CHANNELS - 1);
	assign hs       = head.slot[SW-1:0];

	// a new result word enters the output register this cycle
	assign out_load = (state_q == S_IDLE && head_valid && !need_cal && out_free)
		|| (state_q == S_WAIT && out_free);

	// set-all resolves each slot through the address map again
	assign issue_idx  = (state_q == S_IDLE) ? '0 : iter_q + 1'b1;
	assign issue_byte = chan_map[8*issue_idx +: 8];
	assign all_match  = find_slot(chan_map, issue_byte, NUM_CHANNELS);
	assign all_slot   = all_match.hit ? all_match.slot[SW-1:0] : issue_idx;
	assign issue_slot = (state_q == S_IDLE && head.kind != KIND_SET_ALL) ? hs : all_slot;
	assign cal_idx    = (state_q == S_IDLE) ? head.cal_index : cmd_q.cal_index;
	assign cal_addr   = CAL_AW'(int'(issue_slot) * CAL_ENTRIES + int'(cal_idx));

	assign pop   = state_q == S_IDLE && head_valid && (need_cal || out_free);
	assign rd_en = (state_q == S_IDLE && head_valid && need_cal)
		|| (state_q == S_WAIT && out_free && more);
	assign wr_en = state_q == S_IDLE && head_valid && !need_cal && out_free
		&& head.hit && head.kind == KIND_LOAD;

	// calibrated code, saturating
	assign cal_byte = cal_rd_vld_q ? cal_rd_q : 8'd0;
	assign cal_sum  = {1'b0, cmd_q.code} + {9'd0, cal_byte};
	assign cal_code = cal_sum[16] ? CODE_MAX : cal_sum[15:0];

	assign sp      = setpoint_q[hs];
	assign sp_next = (rem_q[hs] != 16'd0) ? sp + inc_q[hs] : sp;

	// result of a command that needs no calibration lookup
	always_comb begin
		s_frame  = 1'b0;
		s_status = 1'b0;
		s_addr   = 8'd0;
		s_code   = 16'd0;
		s_read   = 16'd0;
		if (known && !head.hit) begin
			s_status = 1'b1;
		end else if (known) begin
			case (head.kind)
				KIND_INIT: begin
					s_frame = 1'b1;
					s_addr  = dac_map[8*hs +: 8];
					s_code  = head.code;
				end
				KIND_NEXT: begin
					if (mode_q[hs]) begin
						s_frame = 1'b1;
						s_addr  = dac_map[8*hs +: 8];
						s_code  = sp_next;
					end
				end
				KIND_READ: begin
					s_read = sp;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			iter_q       <= '0;
			cur_slot_q   <= '0;
			cmd_q        <= '0;
			out_valid_q  <= 1'b0;
			out_frame_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_addr_q   <= 8'd0;
			out_code_q   <= 16'd0;
			out_read_q   <= 16'd0;
			out_last_q   <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				setpoint_q[i] <= 16'd0;
				mode_q[i]     <= 1'b0;
				inc_q[i]      <= 16'd0;
				rem_q[i]      <= 16'd0;
			end
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_valid && need_cal) begin
						cmd_q      <= head;
						cur_slot_q <= issue_slot;
						iter_q     <= '0;
						state_q    <= S_WAIT;
					end else if (head_valid && out_free) begin
						out_frame_q  <= s_frame;
						out_status_q <= s_status;
						out_addr_q   <= s_addr;
						out_code_q   <= s_code;
						out_read_q   <= s_read;
						out_last_q   <= 1'b1;
						if (known && head.hit) begin
							case (head.kind)
								KIND_INIT: begin
									inc_q[hs]      <= head.ramp_step;
									rem_q[hs]      <= head.ramp_count;
									setpoint_q[hs] <= head.code;
									mode_q[hs]     <= 1'b1;
								end
								KIND_NEXT: begin
									if (mode_q[hs] && rem_q[hs] != 16'd0) begin
										setpoint_q[hs] <= sp_next;
										rem_q[hs]      <= rem_q[hs] - 16'd1;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_WAIT: begin
					if (out_free) begin
						out_frame_q  <= 1'b1;
						out_status_q <= 1'b0;
						out_addr_q   <= dac_map[8*cur_slot_q +: 8];
						out_code_q   <= cal_code;
						out_read_q   <= 16'd0;
						out_last_q   <= !more;
						setpoint_q[cur_slot_q] <= cmd_q.code;
						mode_q[cur_slot_q]     <= 1'b0;
						if (more) begin
							iter_q     <= issue_idx;
							cur_slot_q <= issue_slot;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// calibration RAM: one port, registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			cal_rd_q <= cal_mem[cal_addr];
		if (wr_en)
			cal_mem[cal_addr] <= head.cal_value;
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_vld_q    <= '0;
			cal_rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				cal_vld_q[cal_addr] <= 1'b1;
			if (rd_en)
				cal_rd_vld_q <= cal_vld_q[cal_addr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_read_q, out_code_q, out_addr_q};
	assign m_tuser  = {out_status_q, out_frame_q};
	assign m_tlast  = out_last_q;

	`DSRC_ASSERT(a_wait_kind, clk, arst_n, (state_q == S_WAIT) |-> (cmd_q.kind == KIND_SET || cmd_q.kind == KIND_SET_ALL), "lookup wait entered by a command without calibration")
	`DSRC_ASSERT(a_iter_range, clk, arst_n, iter_q <= SW'(NUM_CHANNELS - 1), "set-all iteration out of range")
	`DSRC_ASSERT(a_setall_stays, clk, arst_n, (state_q == S_WAIT && out_free && more) |=> (state_q == S_WAIT), "set-all left before its last channel")

endmodule

// ----- rtl/core/dac_setpoint_ramp_calibrator.sv -----
// DAC setpoint ramp calibrator top: config registers, front end, queue, back end.
// Depends on dsrc_pkg, dsrc_front, dsrc_queue and dsrc_back.
// Path: front-end stages, queue, result word register; set and set-all also pass the RAM read.
// The back end holds set and set-all in a lookup wait state until their last word enters
// the result register. Front end takes one word per cycle while the queue is not full.
// Reset: async active low; clears maps, channel state and calibration valid bits.
module dac_setpoint_ramp_calibrator #(
	parameter int NUM_CHANNELS = dsrc_pkg::DEF_NUM_CHANNELS,   // 1 .. 8
	parameter int CAL_STEP     = dsrc_pkg::DEF_CAL_STEP        // 256 .. 16384
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// channel[7:0], code[23:8], ramp_step[39:24], ramp_count[55:40],
	// cal_index[63:56], cal_value[71:64]
	input  logic [dsrc_pkg::S_DATA_W-1:0]  s_tdata,
	// kind[2:0]
	input  logic [dsrc_pkg::S_USER_W-1:0]  s_tuser,
	// result words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// dac_address[7:0], dac_code[23:8], read_value[39:24]
	output logic [dsrc_pkg::M_DATA_W-1:0]  m_tdata,
	// frame_valid[0], status[1]
	output logic [dsrc_pkg::M_USER_W-1:0]  m_tuser,
	output logic                           m_tlast,
	// register writes
	input  logic                           cfg_we,
	input  logic [dsrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsrc_pkg::MAP_W-1:0]     cfg_data
);
	import dsrc_pkg::*;

	localparam int CMD_W = $bits(cmd_t);

	// Address maps: byte i belongs to channel slot i. The channel map is what
	// commands match against; the DAC map is the address byte put in frames.
	logic [MAP_W-1:0] chan_map_q, dac_map_q;

	logic             fe_push, q_full, q_empty, be_pop;
	cmd_t             fe_cmd, q_head;
	logic [CMD_W-1:0] q_head_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_map_q <= '0;
			dac_map_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHAN_MAP: chan_map_q <= cfg_data;
				CFG_DAC_MAP:  dac_map_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: two register stages. Stage 1 takes the word and starts the
	// reciprocal multiplies; stage 2 holds the slot match and the calibration
	// entry index, then the word is pushed into the queue.
	dsrc_front #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CAL_STEP    (CAL_STEP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.chan_map (chan_map_q),
		.push     (fe_push),
		.push_data(fe_cmd),
		.full     (q_full)
	);

	// Decouples front and back so a stalled result port only backs up
	// the front end once the queue fills.
	dsrc_queue #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_push),
		.push_data(fe_cmd),
		.full     (q_full),
		.pop      (be_pop),
		.pop_data (q_head_bits),
		.empty    (q_empty)
	);

	assign q_head = cmd_t'(q_head_bits);

	// Back end: executes against channel state, looks up the calibration RAM
	// for set and set-all, and owns the result word register.
	dsrc_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CAL_STEP    (CAL_STEP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.head_valid(!q_empty),
		.pop       (be_pop),
		.chan_map  (chan_map_q),
		.dac_map   (dac_map_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for dac_setpoint_ramp_calibrator: a directed table, then random commands.
// Every result word is checked against the oldest expected one: typed in for fixed rows, else predicted here.
// Depends on dsrc_pkg and the calibrator RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dsrc_pkg::*;

	localparam int NUM_CH   = DEF_NUM_CHANNELS;
	localparam int STEP_LSB = DEF_CAL_STEP;
	// calibration entries owned by each slot
	localparam int CAL_ENT  = 65535 / STEP_LSB + 1;
	localparam int DIR_N    = 25;
	// margin after the last word before a register write or the end
	localparam int SETTLE   = 12;

	// kinds the block ignores: one empty word, last set
	localparam logic [2:0] KIND_RSV6 = 3'd6;
	localparam logic [2:0] KIND_RSV7 = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  channel;
		logic [15:0] code;
		logic [15:0] ramp_step;
		logic [15:0] ramp_count;
		logic [7:0]  cal_index;
		logic [7:0]  cal_value;
	} cmd_word_t;

	typedef struct packed {
		logic        frame;
		logic [7:0]  dac_addr;
		logic [15:0] dac_code;
		logic        status;
		logic [15:0] readback;
		logic        last;
	} res_word_t;

	// fixed: the row's result word is typed in below instead of predicted
	typedef struct packed {
		cmd_word_t cmd;
		logic      fixed;
		res_word_t want;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [S_USER_W-1:0]  s_tuser;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic [M_USER_W-1:0]  m_tuser;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MAP_W-1:0]     cfg_data;

	// predictor state, mirrors the block after every accepted word
	logic [63:0] chan_map;
	logic [63:0] dac_map;
	logic [15:0] setpoint   [NUM_CH];
	logic        ramping    [NUM_CH];
	logic [15:0] ramp_inc   [NUM_CH];
	logic [15:0] ramp_left  [NUM_CH];
	logic [7:0]  corr       [CAL_DEPTH];

	res_word_t due_words[$];
	int        fail_cnt  = 0;
	int        idle_pct  = 0;
	int        stall_pct = 0;

	// Directed commands. All maps are zero out of reset, so every slot answers
	// to address 0, slot 0 wins each lookup and every DAC address is 0.
	dir_row_t dir_tab [DIR_N] = '{
		// read right after reset
		'{'{KIND_READ,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{0, 0, 0, 0, 0, 1}},
		// unknown address, each kind that looks one up
		'{'{KIND_SET,     'h80, 'hFFFF, 'hFFFF, 'hFFFF, 'hFF, 'hFF}, 1, '{0, 0, 0, 1, 0, 1}},
		'{'{KIND_INIT,    'hFF, 'h8000, 'h0001, 'h0003, 'h00, 'h00}, 1, '{0, 0, 0, 1, 0, 1}},
		'{'{KIND_NEXT,    'h01, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{0, 0, 0, 1, 0, 1}},
		'{'{KIND_READ,    'h7F, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{0, 0, 0, 1, 0, 1}},
		'{'{KIND_LOAD,    'hAA, 'h0000, 'h0000, 'h0000, 'hFF, 'hFF}, 1, '{0, 0, 0, 1, 0, 1}},
		// reserved kinds
		'{'{KIND_RSV6,    'h12, 'hFFFF, 'hFFFF, 'hFFFF, 'hFF, 'hFF}, 1, '{0, 0, 0, 0, 0, 1}},
		'{'{KIND_RSV7,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{0, 0, 0, 0, 0, 1}},
		// ramp step on a channel in static mode: no frame
		'{'{KIND_NEXT,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{0, 0, 0, 0, 0, 1}},
		// top code with an empty calibration store
		'{'{KIND_SET,     'h00, 'hFFFF, 'h0000, 'h0000, 'h00, 'h00}, 1, '{1, 0, 'hFFFF, 0, 0, 1}},
		// top entry gets FF, then hit it exactly and past the top
		'{'{KIND_LOAD,    'h00, 'h0000, 'h0000, 'h0000, 'd63, 'hFF}, 1, '{0, 0, 0, 0, 0, 1}},
		'{'{KIND_SET,     'h00, 'hFF00, 'h0000, 'h0000, 'h00, 'h00}, 1, '{1, 0, 'hFFFF, 0, 0, 1}},
		'{'{KIND_SET,     'h00, 'hFFFF, 'h0000, 'h0000, 'h00, 'h00}, 1, '{1, 0, 'hFFFF, 0, 0, 1}},
		// load index past the slot's entries folds back to entry 8
		'{'{KIND_LOAD,    'h00, 'h0000, 'h0000, 'h0000, 'd200, 'h10}, 1, '{0, 0, 0, 0, 0, 1}},
		'{'{KIND_SET,     'h00, 'h2000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{1, 0, 'h2010, 0, 0, 1}},
		// read returns the raw code, not the corrected one
		'{'{KIND_READ,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{0, 0, 0, 0, 'h2000, 1}},
		'{'{KIND_SET,     'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 1, '{1, 0, 'h0000, 0, 0, 1}},
		// ramp from the top that wraps, then runs out of steps
		'{'{KIND_INIT,    'h00, 'hFFFF, 'h0002, 'h0002, 'h00, 'h00}, 1, '{1, 0, 'hFFFF, 0, 0, 1}},
		'{'{KIND_NEXT,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 0, '0},
		'{'{KIND_NEXT,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 0, '0},
		'{'{KIND_NEXT,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 0, '0},
		// ramp armed with a zero count holds its start value
		'{'{KIND_INIT,    'h00, 'h1234, 'h0100, 'h0000, 'h00, 'h00}, 1, '{1, 0, 'h1234, 0, 0, 1}},
		'{'{KIND_NEXT,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 0, '0},
		// set-all with every slot on the same address: slot 0 four times
		'{'{KIND_SET_ALL, 'h00, 'h2000, 'h0000, 'h0000, 'h00, 'h00}, 0, '0},
		'{'{KIND_READ,    'h00, 'h0000, 'h0000, 'h0000, 'h00, 'h00}, 0, '0}
	};

	dac_setpoint_ramp_calibrator #(
		.NUM_CHANNELS(NUM_CH),
		.CAL_STEP    (STEP_LSB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5ns clk = ~clk;

	// first slot whose user address matches, -1 if none
	function automatic int lookup_slot(logic [7:0] addr);
		for (int i = 0; i < NUM_CH; i++)
			if (chan_map[8*i +: 8] == addr)
				return i;
		return -1;
	endfunction

	// set path: corrected code goes out, raw code is stored, ramp is dropped
	function automatic void emit_frame(int slot, logic [15:0] code, logic last);
		res_word_t  w;
		logic [16:0] sum;
		sum = code + corr[(slot * CAL_ENT + int'(code) / STEP_LSB) % CAL_DEPTH];
		setpoint[slot] = code;
		ramping[slot]  = 1'b0;
		w          = '0;
		w.frame    = 1'b1;
		w.dac_addr = dac_map[8*slot +: 8];
		w.dac_code = sum[16] ? CODE_MAX : sum[15:0];
		w.last     = last;
		due_words.push_back(w);
	endfunction

	// advance the predictor by one accepted command and queue its words
	function automatic void apply_command(cmd_word_t c);
		res_word_t w;
		int        slot;
		w      = '0;
		w.last = 1'b1;
		if (c.kind == KIND_SET_ALL) begin
			// each slot's own address is looked up again, duplicates hit the first
			for (int i = 0; i < NUM_CH; i++)
				emit_frame(lookup_slot(chan_map[8*i +: 8]), c.code, i == NUM_CH - 1);
			return;
		end
		if (c.kind > KIND_LOAD) begin
			due_words.push_back(w);
			return;
		end
		slot = lookup_slot(c.channel);
		if (slot < 0) begin
			w.status = 1'b1;
			due_words.push_back(w);
			return;
		end
		case (c.kind)
			KIND_SET: begin
				emit_frame(slot, c.code, 1'b1);
			end
			KIND_INIT: begin
				ramp_inc[slot]  = c.ramp_step;
				ramp_left[slot] = c.ramp_count;
				setpoint[slot]  = c.code;
				ramping[slot]   = 1'b1;
				w.frame    = 1'b1;
				w.dac_addr = dac_map[8*slot +: 8];
				w.dac_code = c.code;
				due_words.push_back(w);
			end
			KIND_NEXT: begin
				if (ramping[slot]) begin
					if (ramp_left[slot] != 16'd0) begin
						setpoint[slot]  = setpoint[slot] + ramp_inc[slot];
						ramp_left[slot] = ramp_left[slot] - 16'd1;
					end
					w.frame    = 1'b1;
					w.dac_addr = dac_map[8*slot +: 8];
					w.dac_code = setpoint[slot];
				end
				due_words.push_back(w);
			end
			KIND_READ: begin
				w.readback = setpoint[slot];
				due_words.push_back(w);
			end
			default: begin
				corr[(slot * CAL_ENT + int'(c.cal_index) % CAL_ENT) % CAL_DEPTH] = c.cal_value;
				due_words.push_back(w);
			end
		endcase
	endfunction

	// correction index near the bottom or the top of the code range
	function automatic logic [5:0] cal_bucket();
		int b;
		b = $urandom_range(7);
		return (b < 4) ? 6'(b) : 6'(56 + b);
	endfunction

	function automatic cmd_word_t rand_command();
		cmd_word_t c;
		int        pick;
		int        slot;
		pick = $urandom_range(99);
		if (pick < 20)      c.kind = KIND_SET;
		else if (pick < 28) c.kind = KIND_SET_ALL;
		else if (pick < 40) c.kind = KIND_INIT;
		else if (pick < 62) c.kind = KIND_NEXT;
		else if (pick < 76) c.kind = KIND_READ;
		else if (pick < 94) c.kind = KIND_LOAD;
		else if (pick < 97) c.kind = KIND_RSV6;
		else                c.kind = KIND_RSV7;
		// mostly a mapped address, now and then anything
		slot = $urandom_range(NUM_CH - 1);
		c.channel    = ($urandom_range(99) < 85) ? chan_map[8*slot +: 8] : 8'($urandom);
		// codes and loads share a few correction entries so they meet
		c.code       = ($urandom_range(99) < 60) ? {cal_bucket(), 10'($urandom)} : 16'($urandom);
		c.ramp_step  = 16'($urandom);
		c.ramp_count = ($urandom_range(99) < 70) ? 16'($urandom_range(3)) : 16'($urandom);
		c.cal_index  = ($urandom_range(99) < 60) ? {2'($urandom), cal_bucket()} : 8'($urandom);
		c.cal_value  = 8'($urandom);
		return c;
	endfunction

	// random map whose live bytes are all different
	function automatic logic [63:0] distinct_map();
		logic [63:0] m;
		logic        clash;
		m = {$urandom, $urandom};
		for (int i = 1; i < NUM_CH; i++) begin
			do begin
				clash = 1'b0;
				for (int j = 0; j < i; j++)
					if (m[8*i +: 8] == m[8*j +: 8])
						clash = 1'b1;
				if (clash)
					m[8*i +: 8] = 8'($urandom);
			end while (clash);
		end
		return m;
	endfunction

	// called at a rising edge, returns at the edge where the word is taken
	task automatic send_command(cmd_word_t c);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.kind;
		s_tdata  <= {c.cal_value, c.cal_index, c.ramp_count, c.ramp_step, c.code, c.channel};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_command(c);
	endtask

	// nothing in flight afterwards, so the maps may be rewritten
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_maps(logic [63:0] chan, logic [63:0] dac);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CHAN_MAP;
		cfg_data  <= chan;
		@(posedge clk);
		cfg_index <= CFG_DAC_MAP;
		cfg_data  <= dac;
		@(posedge clk);
		cfg_we   <= 1'b0;
		chan_map = chan;
		dac_map  = dac;
	endtask

	// one map setting, one idle/stall mix; ramp bursts get past the init state
	task automatic run_phase(logic [63:0] chan, logic [63:0] dac, int idle, int stall, int n);
		cmd_word_t c;
		int        sent;
		int        slot;
		int        k;
		load_maps(chan, dac);
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 30) begin
				c         = rand_command();
				slot      = $urandom_range(NUM_CH - 1);
				c.kind    = KIND_INIT;
				c.channel = chan[8*slot +: 8];
				send_command(c);
				k = $urandom_range(5, 1);
				c.kind = KIND_NEXT;
				repeat (k) send_command(c);
				sent += k + 1;
			end else begin
				send_command(rand_command());
				sent++;
			end
		end
		wait_idle();
	endtask

	// result side: random back-pressure, and each taken word against the oldest expectation
	always @(posedge clk) begin
		res_word_t got;
		res_word_t want;
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got.frame    = m_tuser[0];
			got.status   = m_tuser[1];
			got.dac_addr = m_tdata[7:0];
			got.dac_code = m_tdata[23:8];
			got.readback = m_tdata[39:24];
			got.last     = m_tlast;
			if (due_words.size() == 0) begin
				$display("%0t: word with nothing expected: frame=%0d addr=%02h code=%04h",
					$time, got.frame, got.dac_addr, got.dac_code);
				fail_cnt++;
			end else begin
				want = due_words.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected frame=%0d addr=%02h code=%04h st=%0d rd=%04h last=%0d",
						$time, want.frame, want.dac_addr, want.dac_code, want.status,
						want.readback, want.last);
					$display("%0t:          actual   frame=%0d addr=%02h code=%04h st=%0d rd=%04h last=%0d",
						$time, got.frame, got.dac_addr, got.dac_code, got.status,
						got.readback, got.last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		logic [63:0] dup_map;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		chan_map  = '0;
		dac_map   = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			setpoint[i]  = '0;
			ramping[i]   = 1'b0;
			ramp_inc[i]  = '0;
			ramp_left[i] = '0;
		end
		for (int i = 0; i < CAL_DEPTH; i++)
			corr[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows on the reset maps, no idling
		for (int r = 0; r < DIR_N; r++) begin
			send_command(dir_tab[r].cmd);
			if (dir_tab[r].fixed) begin
				void'(due_words.pop_back());
				due_words.push_back(dir_tab[r].want);
			end
		end
		wait_idle();

		// distinct addresses, free running
		run_phase(distinct_map(), {$urandom, $urandom}, 0, 0, 19);
		// all-ones maps: every slot on address FF, sender idles
		run_phase('1, '1, 49, 0, 19);
		// slots 0 and 2 share an address, receiver stalls
		dup_map = distinct_map();
		dup_map[23:16] = dup_map[7:0];
		run_phase(dup_map, {$urandom, $urandom}, 0, 49, 19);
		// both sides idle
		run_phase(distinct_map(), {$urandom, $urandom}, 35, 35, 19);

		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
